>>> src/process_scheduler_fifo_sjf_stcf_rr_core_macros.svh
// Assertion macros used by the scheduler core.
`ifndef PROCESS_SCHEDULER_FIFO_SJF_STCF_RR_CORE_MACROS_SVH
`define PROCESS_SCHEDULER_FIFO_SJF_STCF_RR_CORE_MACROS_SVH
// Same-cycle implication, checked out of reset.
`define PSCH_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define PSCH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> src/psch_pkg.sv
// Types and constants shared by the scheduler modules.
package psch_pkg;
    localparam int MAX_JOBS_DEF  = 16;
    localparam int PID_BITS_DEF  = 8;
    localparam int TIME_BITS_DEF = 16;

    typedef enum logic [1:0] {
        POL_FIFO = 2'd0,
        POL_SJF  = 2'd1,
        POL_STCF = 2'd2,
        POL_RR   = 2'd3
    } policy_t;

    typedef enum logic [0:0] {
        OP_TICK   = 1'b0,
        OP_ARRIVE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_RUN,
        ST_OUT
    } state_t;

    // Queue operations for one cycle.
    typedef struct packed {
        logic push;    // write at tail, occupancy grows; ignored when full
        logic remove;  // take out at index, later entries close the gap
        logic append;  // with remove: write at new tail, occupancy unchanged
    } q_ctrl_t;
endpackage

>>> src/psch_queue.sv
// Ordered ready queue with tail push, removal at an index and one read port.
module psch_queue #(
    parameter int MAX_JOBS  = psch_pkg::MAX_JOBS_DEF,
    parameter int PID_BITS  = psch_pkg::PID_BITS_DEF,
    parameter int TIME_BITS = psch_pkg::TIME_BITS_DEF,
    parameter int IDX_W     = $clog2(MAX_JOBS),
    parameter int CNT_W     = $clog2(MAX_JOBS + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  psch_pkg::q_ctrl_t     ctrl,
    input  logic [IDX_W-1:0]      rm_idx,
    input  logic [PID_BITS-1:0]   wr_pid,
    input  logic [TIME_BITS-1:0]  wr_rem,
    input  logic [TIME_BITS-1:0]  wr_arr,
    input  logic                  wr_started,
    input  logic [IDX_W-1:0]      rd_idx,
    output logic [PID_BITS-1:0]   rd_pid,
    output logic [TIME_BITS-1:0]  rd_rem,
    output logic [TIME_BITS-1:0]  rd_arr,
    output logic                  rd_started,
    output logic [CNT_W-1:0]      occ
);
    import psch_pkg::*;

    logic [PID_BITS-1:0]  pid_reg  [MAX_JOBS];
    logic [TIME_BITS-1:0] rem_reg  [MAX_JOBS];
    logic [TIME_BITS-1:0] arr_reg  [MAX_JOBS];
    logic                 strt_reg [MAX_JOBS];
    logic [PID_BITS-1:0]  pid_next  [MAX_JOBS];
    logic [TIME_BITS-1:0] rem_next  [MAX_JOBS];
    logic [TIME_BITS-1:0] arr_next  [MAX_JOBS];
    logic                 strt_next [MAX_JOBS];
    logic [CNT_W-1:0]     occ_reg, occ_next;
    logic [CNT_W-1:0]     tail;

    assign rd_pid     = pid_reg[rd_idx];
    assign rd_rem     = rem_reg[rd_idx];
    assign rd_arr     = arr_reg[rd_idx];
    assign rd_started = strt_reg[rd_idx];
    assign occ        = occ_reg;

    always_comb begin
        occ_next = occ_reg;
        tail     = occ_reg;
        if (ctrl.remove) begin
            tail = occ_reg - CNT_W'(1);
            if (!ctrl.append) begin
                occ_next = occ_reg - CNT_W'(1);
            end
        end else if (ctrl.push && occ_reg < CNT_W'(MAX_JOBS)) begin
            occ_next = occ_reg + CNT_W'(1);
        end
        for (int i = 0; i < MAX_JOBS; i++) begin
            pid_next[i]  = pid_reg[i];
            rem_next[i]  = rem_reg[i];
            arr_next[i]  = arr_reg[i];
            strt_next[i] = strt_reg[i];
            if (ctrl.remove && i < MAX_JOBS - 1 && CNT_W'(i) >= CNT_W'(rm_idx)) begin
                pid_next[i]  = pid_reg[(i + 1) % MAX_JOBS];
                rem_next[i]  = rem_reg[(i + 1) % MAX_JOBS];
                arr_next[i]  = arr_reg[(i + 1) % MAX_JOBS];
                strt_next[i] = strt_reg[(i + 1) % MAX_JOBS];
            end
            if ((ctrl.push || (ctrl.remove && ctrl.append)) && CNT_W'(i) == tail) begin
                pid_next[i]  = wr_pid;
                rem_next[i]  = wr_rem;
                arr_next[i]  = wr_arr;
                strt_next[i] = wr_started;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_JOBS; i++) begin
            pid_reg[i]  <= pid_next[i];
            rem_reg[i]  <= rem_next[i];
            arr_reg[i]  <= arr_next[i];
            strt_reg[i] <= strt_next[i];
        end
    end
endmodule

>>> src/process_scheduler_fifo_sjf_stcf_rr_core.sv
// Unit-time job scheduler with FIFO, SJF, STCF and round robin policies.
//
// Usage: one beat on the s_ channel is either an arrival (s_tuser = 1, tdata holds the
// job id and burst) or a time tick (s_tuser = 0). Every input beat yields exactly one
// beat on the m_ channel that reports the time, whether an arrival was queued, which
// job ran on a tick, its first-run response time, completion with turnaround time,
// and the number of waiting jobs. The policy register is written through cfg_we and
// cfg_wdata; write it only while the block is idle, which the block does not enforce.
// Sequence: an arrival goes from acceptance straight to ST_OUT; a tick that neither
// dispatches nor scans passes through ST_RUN, and a FIFO or RR dispatch through ST_PICK
// and ST_RUN. A tick that dispatches under SJF or STCF, or checks preemption under STCF,
// first walks the ready queue in ST_SCAN with one shared compare unit, one entry a
// cycle, then goes through ST_PICK and ST_RUN; every item ends in ST_OUT.
// Flow: one item at a time; s_tready is high only when the block is idle and no
// result is waiting, so a new item is taken only once the receiver has taken the
// last result and the block is back in idle.
// Reset clears time, the queue occupancy, the running job and the policy (FIFO). While
// the receiver holds m_tready low the result is held stable and no input is taken.
`include "process_scheduler_fifo_sjf_stcf_rr_core_macros.svh"

module process_scheduler_fifo_sjf_stcf_rr_core #(
    parameter int MAX_JOBS  = psch_pkg::MAX_JOBS_DEF,
    parameter int PID_BITS  = psch_pkg::PID_BITS_DEF,
    parameter int TIME_BITS = psch_pkg::TIME_BITS_DEF,
    parameter int CNT_W     = $clog2(MAX_JOBS + 1),
    parameter int IN_W      = ((PID_BITS + TIME_BITS + 7) / 8) * 8,
    parameter int OUT_RAW   = 3 * TIME_BITS + PID_BITS + 4 + CNT_W,
    parameter int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    // tdata: process_id, burst_length, zero fill.
    input  logic [IN_W-1:0]   s_tdata,
    // tuser: operation.
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // tdata: tick_time, accepted, running_valid, running_pid, first_run,
    // response_time, finished, turnaround_time, ready_count, zero fill.
    output logic [OUT_W-1:0]  m_tdata
);
    import psch_pkg::*;

    localparam int IDX_W = $clog2(MAX_JOBS);

    state_t               state_reg, state_next;
    policy_t              policy_reg;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [PID_BITS-1:0]  cur_pid_reg, cur_pid_next;
    logic [TIME_BITS-1:0] cur_rem_reg, cur_rem_next;
    logic [TIME_BITS-1:0] cur_arr_reg, cur_arr_next;
    logic                 cur_strt_reg, cur_strt_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [TIME_BITS-1:0] best_rem_reg, best_rem_next;
    logic [TIME_BITS-1:0] best_age_reg, best_age_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 acc_reg, acc_next;
    logic                 rv_reg, rv_next;
    logic [PID_BITS-1:0]  rpid_reg, rpid_next;
    logic                 fr_reg, fr_next;
    logic [TIME_BITS-1:0] resp_reg, resp_next;
    logic                 fin_reg, fin_next;
    logic [TIME_BITS-1:0] ta_reg, ta_next;

    q_ctrl_t              qctl;
    logic [IDX_W-1:0]     rm_idx, rd_idx;
    logic [PID_BITS-1:0]  wr_pid, rd_pid;
    logic [TIME_BITS-1:0] wr_rem, wr_arr, rd_rem, rd_arr;
    logic                 wr_started, rd_started;
    logic [CNT_W-1:0]     occ;

    logic [PID_BITS-1:0]  in_pid;
    logic [TIME_BITS-1:0] in_burst, rd_age, rem_dec;
    logic                 shortest_pol, take;

    assign in_pid       = s_tdata[PID_BITS-1:0];
    assign in_burst     = s_tdata[PID_BITS +: TIME_BITS];
    assign shortest_pol = (policy_reg == POL_SJF) || (policy_reg == POL_STCF);
    assign s_tready     = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_tvalid     = m_valid_reg;
    assign rd_age       = time_reg - rd_arr;
    assign rem_dec      = cur_rem_reg - TIME_BITS'(1);

    // Shared compare unit: less remaining time wins, then the older job.
    assign take = (scan_reg == '0) || (rd_rem < best_rem_reg) ||
                  ((rd_rem == best_rem_reg) && (rd_age > best_age_reg));

    assign m_tdata = OUT_W'({occ, ta_reg, fin_reg, resp_reg, fr_reg, rpid_reg,
                             rv_reg, acc_reg, time_reg});

    psch_queue #(
        .MAX_JOBS(MAX_JOBS), .PID_BITS(PID_BITS), .TIME_BITS(TIME_BITS),
        .IDX_W(IDX_W), .CNT_W(CNT_W)
    ) u_queue (
        .aclk(aclk), .aresetn(aresetn), .ctrl(qctl), .rm_idx(rm_idx),
        .wr_pid(wr_pid), .wr_rem(wr_rem), .wr_arr(wr_arr), .wr_started(wr_started),
        .rd_idx(rd_idx), .rd_pid(rd_pid), .rd_rem(rd_rem), .rd_arr(rd_arr),
        .rd_started(rd_started), .occ(occ)
    );

    always_comb begin
        state_next     = state_reg;
        time_next      = time_reg;
        cur_valid_next = cur_valid_reg;
        cur_pid_next   = cur_pid_reg;
        cur_rem_next   = cur_rem_reg;
        cur_arr_next   = cur_arr_reg;
        cur_strt_next  = cur_strt_reg;
        scan_next      = scan_reg;
        best_idx_next  = best_idx_reg;
        best_rem_next  = best_rem_reg;
        best_age_next  = best_age_reg;
        m_valid_next   = m_valid_reg;
        acc_next       = acc_reg;
        rv_next        = rv_reg;
        rpid_next      = rpid_reg;
        fr_next        = fr_reg;
        resp_next      = resp_reg;
        fin_next       = fin_reg;
        ta_next        = ta_reg;
        qctl           = '0;
        rm_idx         = '0;
        rd_idx         = '0;
        wr_pid         = cur_pid_reg;
        wr_rem         = cur_rem_reg;
        wr_arr         = cur_arr_reg;
        wr_started     = cur_strt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (m_valid_reg && m_tready) begin
                    m_valid_next = 1'b0;
                end
                if (s_tvalid && s_tready) begin
                    acc_next  = 1'b0;
                    rv_next   = 1'b0;
                    rpid_next = '0;
                    fr_next   = 1'b0;
                    resp_next = '0;
                    fin_next  = 1'b0;
                    ta_next   = '0;
                    scan_next = '0;
                    if (op_t'(s_tuser) == OP_ARRIVE) begin
                        wr_pid     = in_pid;
                        wr_rem     = (in_burst == '0) ? TIME_BITS'(1) : in_burst;
                        wr_arr     = time_reg;
                        wr_started = 1'b0;
                        qctl.push  = 1'b1;
                        acc_next   = occ < CNT_W'(MAX_JOBS);
                        state_next = ST_OUT;
                    end else begin
                        time_next = time_reg + TIME_BITS'(1);
                        if (occ != '0 && ((cur_valid_reg && policy_reg == POL_STCF) ||
                                          (!cur_valid_reg && shortest_pol))) begin
                            state_next = ST_SCAN;
                        end else if (occ != '0 && !cur_valid_reg) begin
                            best_idx_next = '0;
                            state_next    = ST_PICK;
                        end else begin
                            state_next = ST_RUN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                rd_idx = scan_reg[IDX_W-1:0];
                if (take) begin
                    best_idx_next = scan_reg[IDX_W-1:0];
                    best_rem_next = rd_rem;
                    best_age_next = rd_age;
                end
                scan_next = scan_reg + CNT_W'(1);
                if (scan_reg + CNT_W'(1) == occ) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                rd_idx = best_idx_reg;
                rm_idx = best_idx_reg;
                if (!cur_valid_reg || rd_rem < cur_rem_reg) begin
                    qctl.remove    = 1'b1;
                    qctl.append    = cur_valid_reg;
                    cur_valid_next = 1'b1;
                    cur_pid_next   = rd_pid;
                    cur_rem_next   = rd_rem;
                    cur_arr_next   = rd_arr;
                    cur_strt_next  = rd_started;
                end
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (cur_valid_reg) begin
                    rv_next       = 1'b1;
                    rpid_next     = cur_pid_reg;
                    cur_strt_next = 1'b1;
                    cur_rem_next  = rem_dec;
                    if (!cur_strt_reg) begin
                        fr_next   = 1'b1;
                        resp_next = time_reg - cur_arr_reg;
                    end
                    if (rem_dec == '0) begin
                        fin_next       = 1'b1;
                        ta_next        = time_reg - cur_arr_reg;
                        cur_valid_next = 1'b0;
                    end else if (policy_reg == POL_RR && occ != '0) begin
                        wr_rem        = rem_dec;
                        wr_started    = 1'b1;
                        qctl.remove   = 1'b1;
                        qctl.append   = 1'b1;
                        cur_pid_next  = rd_pid;
                        cur_rem_next  = rd_rem;
                        cur_arr_next  = rd_arr;
                        cur_strt_next = rd_started;
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            policy_reg    <= POL_FIFO;
            time_reg      <= '0;
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_we) begin
                policy_reg <= policy_t'(cfg_wdata);
            end
            time_reg      <= time_next;
            cur_valid_reg <= cur_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_pid_reg  <= cur_pid_next;
        cur_rem_reg  <= cur_rem_next;
        cur_arr_reg  <= cur_arr_next;
        cur_strt_reg <= cur_strt_next;
        scan_reg     <= scan_next;
        best_idx_reg <= best_idx_next;
        best_rem_reg <= best_rem_next;
        best_age_reg <= best_age_next;
        acc_reg      <= acc_next;
        rv_reg       <= rv_next;
        rpid_reg     <= rpid_next;
        fr_reg       <= fr_next;
        resp_reg     <= resp_next;
        fin_reg      <= fin_next;
        ta_reg       <= ta_next;
    end

    `PSCH_ASSERT(a_occ_bound, 1'b1, occ <= CNT_W'(MAX_JOBS), "ready queue overflow")
    `PSCH_ASSERT(a_fin_ran, m_valid_reg, !fin_reg || rv_reg, "finish without a running job")
    `PSCH_ASSERT(a_scan_range, state_reg == ST_SCAN, scan_reg < occ, "scan beyond queue")
    `PSCH_ASSERT_NXT(a_run_out, state_reg == ST_RUN, state_reg == ST_OUT && !m_valid_reg,
        "run step not followed by result")
endmodule

>>> tb/process_scheduler_fifo_sjf_stcf_rr_core_checker.sv
// Result checker for the scheduler: watches both channels, predicts and compares.
module process_scheduler_fifo_sjf_stcf_rr_core_checker
    import psch_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic [4:0]  ready_count;
        logic [15:0] turnaround_time;
        logic        finished;
        logic [15:0] response_time;
        logic        first_run;
        logic [7:0]  running_pid;
        logic        running_valid;
        logic        accepted;
        logic [15:0] tick_time;
    } sched_report_t;

    typedef struct {
        logic [7:0]  pid;
        logic [15:0] remaining;
        logic [15:0] arrival;
        logic        started;
    } job_rec_t;

    policy_t       pol;
    logic [15:0]   now;
    job_rec_t      waiting[$];
    logic          busy;
    job_rec_t      cur;
    sched_report_t expected_reports[$];

    // Least remaining time, then the oldest, then nearest the head.
    function automatic int shortest_index();
        int best;
        logic [15:0] ab, ai;
        best = 0;
        for (int i = 1; i < waiting.size(); i++) begin
            ab = now - waiting[best].arrival;
            ai = now - waiting[i].arrival;
            if (waiting[i].remaining < waiting[best].remaining ||
                (waiting[i].remaining == waiting[best].remaining && ai > ab))
                best = i;
        end
        return best;
    endfunction

    task automatic schedule_item(input logic op, input logic [7:0] pid,
                                 input logic [15:0] burst);
        sched_report_t r;
        job_rec_t j;
        int b;
        r = '0;
        if (op == OP_ARRIVE) begin
            if (waiting.size() < 16) begin
                j.pid = pid;
                j.remaining = (burst == 0) ? 16'd1 : burst;
                j.arrival = now;
                j.started = 1'b0;
                waiting.push_back(j);
                r.accepted = 1'b1;
            end
        end else begin
            now = now + 16'd1;
            if (busy && pol == POL_STCF && waiting.size() > 0) begin
                b = shortest_index();
                if (waiting[b].remaining < cur.remaining) begin
                    j = cur;
                    cur = waiting[b];
                    waiting.delete(b);
                    waiting.push_back(j);
                end
            end
            if (!busy && waiting.size() > 0) begin
                b = (pol == POL_SJF || pol == POL_STCF) ? shortest_index() : 0;
                cur = waiting[b];
                waiting.delete(b);
                busy = 1'b1;
            end
            if (busy) begin
                r.running_valid = 1'b1;
                r.running_pid = cur.pid;
                if (!cur.started) begin
                    cur.started = 1'b1;
                    r.first_run = 1'b1;
                    r.response_time = now - cur.arrival;
                end
                cur.remaining = cur.remaining - 16'd1;
                if (cur.remaining == 0) begin
                    r.finished = 1'b1;
                    r.turnaround_time = now - cur.arrival;
                    busy = 1'b0;
                end else if (pol == POL_RR && waiting.size() > 0) begin
                    j = cur;
                    cur = waiting.pop_front();
                    waiting.push_back(j);
                end
            end
        end
        r.tick_time = now;
        r.ready_count = 5'(waiting.size());
        expected_reports.push_back(r);
    endtask

    task automatic compare_report(input sched_report_t e, input sched_report_t a);
        if (a.tick_time !== e.tick_time) begin
            $error("tick_time expected %0d got %0d", e.tick_time, a.tick_time);
            fail_count++;
        end
        if (a.accepted !== e.accepted) begin
            $error("accepted expected %0d got %0d", e.accepted, a.accepted);
            fail_count++;
        end
        if (a.running_valid !== e.running_valid) begin
            $error("running_valid expected %0d got %0d", e.running_valid, a.running_valid);
            fail_count++;
        end
        if (a.running_pid !== e.running_pid) begin
            $error("running_pid expected %0d got %0d", e.running_pid, a.running_pid);
            fail_count++;
        end
        if (a.first_run !== e.first_run) begin
            $error("first_run expected %0d got %0d", e.first_run, a.first_run);
            fail_count++;
        end
        if (a.response_time !== e.response_time) begin
            $error("response_time expected %0d got %0d", e.response_time, a.response_time);
            fail_count++;
        end
        if (a.finished !== e.finished) begin
            $error("finished expected %0d got %0d", e.finished, a.finished);
            fail_count++;
        end
        if (a.turnaround_time !== e.turnaround_time) begin
            $error("turnaround_time expected %0d got %0d",
                   e.turnaround_time, a.turnaround_time);
            fail_count++;
        end
        if (a.ready_count !== e.ready_count) begin
            $error("ready_count expected %0d got %0d", e.ready_count, a.ready_count);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        pol = POL_FIFO;
        now = '0;
        busy = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            pol = POL_FIFO;
            now = '0;
            busy = 1'b0;
            waiting.delete();
            expected_reports.delete();
            pending = 0;
        end else begin
            if (cfg_we) pol = policy_t'(cfg_wdata);
            if (s_tvalid && s_tready) schedule_item(s_tuser, s_tdata[7:0], s_tdata[23:8]);
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    fail_count++;
                end else begin
                    compare_report(expected_reports.pop_front(), m_tdata[64:0]);
                end
            end
            pending = expected_reports.size();
        end
    end
endmodule

>>> tb/process_scheduler_fifo_sjf_stcf_rr_core_tb.sv
// Testbench top for the scheduler: clock, reset, stimulus and verdict.
module process_scheduler_fifo_sjf_stcf_rr_core_tb;
    import psch_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    // tdata: process_id, burst_length.
    logic [23:0] s_tdata;
    // tuser: operation.
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // tdata: tick_time, accepted, running_valid, running_pid, first_run,
    // response_time, finished, turnaround_time, ready_count, zero fill.
    logic [71:0] m_tdata;

    int fail_count;
    int pending;
    int cycle_count;
    // Percent chance per cycle that the sender or the receiver holds off.
    int send_gap_pct;
    int recv_stall_pct;

    process_scheduler_fifo_sjf_stcf_rr_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    process_scheduler_fifo_sjf_stcf_rr_core_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // The receiver stalls at random; a fresh decision is taken every cycle.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // A watchdog far above the slowest legal run: about 800 items, each stretched
    // by heavy stalls on either side.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Drives one beat, optionally after random idle cycles, and waits for the
    // handshake. Unless idle cycles are drawn, the valid stays high from one beat into the next without a gap.
    task automatic send_item(input op_t op, input logic [7:0] pid, input logic [15:0] burst);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {burst, pid};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic tick();
        send_item(OP_TICK, 8'($urandom), 16'($urandom));
    endtask

    task automatic arrive(input logic [7:0] pid, input logic [15:0] burst);
        send_item(OP_ARRIVE, pid, burst);
    endtask

    // Waits until every result is in and the block has gone quiet, then
    // writes the policy register.
    task automatic set_policy(input policy_t p);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= p;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Sends n ticks, meant to let the running job and the queue drain.
    task automatic drain_ticks(input int n);
        for (int i = 0; i < n; i++) tick();
    endtask

    // Random phase for one policy: mostly short bursts so jobs finish, with
    // occasional long bursts and bouts of arrivals that fill the queue.
    task automatic random_phase(input int items);
        int burst_hi;
        for (int i = 0; i < items; i++) begin
            if (i == items / 3) begin
                send_gap_pct = 85; recv_stall_pct = 16;
            end else if (i == 2 * items / 3) begin
                send_gap_pct = 0; recv_stall_pct = 0;
            end
            if ($urandom_range(99) < 45) begin
                burst_hi = ($urandom_range(19) == 0) ? 65535 : 6;
                arrive(8'($urandom), 16'($urandom_range(burst_hi)));
            end else begin
                tick();
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cycle_count = 0;
        send_gap_pct = 16;
        recv_stall_pct = 85;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset policy, FIFO: idle tick, field
        // extremes, a zero burst that counts as one unit, a full queue that
        // drops arrivals, and arrivals while a job runs.
        tick();
        arrive(8'h00, 16'd0);
        arrive(8'hFF, 16'hFFFF);
        arrive(8'hA5, 16'd1);
        tick();
        tick();
        for (int i = 0; i < 16; i++) arrive(8'(i), 16'h5A5A ^ 16'(i));
        arrive(8'h5A, 16'd2);
        tick();
        tick();

        // Bring the block back to an empty queue by reset-free means is too
        // slow with huge bursts, so later phases rely on each other; the
        // random mix keeps most bursts short.
        set_policy(POL_SJF);
        arrive(8'h11, 16'd3);
        arrive(8'h22, 16'd1);
        drain_ticks(4);
        set_policy(POL_STCF);
        arrive(8'h33, 16'd2);
        tick();
        arrive(8'h44, 16'd1);
        drain_ticks(3);
        set_policy(POL_RR);
        arrive(8'h55, 16'd2);
        arrive(8'h66, 16'd2);
        drain_ticks(4);

        set_policy(POL_FIFO);
        random_phase(170);
        set_policy(POL_SJF);
        send_gap_pct = 16; recv_stall_pct = 85;
        random_phase(170);
        set_policy(POL_STCF);
        send_gap_pct = 16; recv_stall_pct = 85;
        random_phase(170);
        set_policy(POL_RR);
        send_gap_pct = 16; recv_stall_pct = 85;
        random_phase(170);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+src
src/psch_pkg.sv
src/psch_queue.sv
src/process_scheduler_fifo_sjf_stcf_rr_core.sv
tb/process_scheduler_fifo_sjf_stcf_rr_core_checker.sv
tb/process_scheduler_fifo_sjf_stcf_rr_core_tb.sv
